FILE: hdl/quadratic_lane_point_predictor_macros.svh
// assertion macros used by the checker of the lane point predictor
`ifndef QUADRATIC_LANE_POINT_PREDICTOR_MACROS_SVH
`define QUADRATIC_LANE_POINT_PREDICTOR_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define QLPP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qlpp check failed");

// consequent checked in the cycle after the antecedent
`define QLPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qlpp check failed");

`endif

FILE: hdl/qlpp_pkg.sv
package qlpp_pkg;

   localparam int IMAGE_ROWS     = 480;
   localparam int ROW_OFFSET     = 130;
   localparam int COEF_FRAC_BITS = 24;
   localparam int TARGET_ROW     = IMAGE_ROWS - ROW_OFFSET;

   localparam int COEF_W = 48;
   localparam int ROW_W  = 9;
   localparam int REF_W  = 32;
   localparam int NREF   = 4;
   localparam int NROW   = NREF + 1;
   localparam int NDIV   = 2 * NROW;
   localparam int HALF_W = COEF_W / 2;
   localparam int PROD_W = 2 * COEF_W;

   // radicand below 2^98, so its square root fits SQ_W bits
   localparam int RAD_W = 100;
   localparam int SQ_W  = RAD_W / 2;
   localparam int N_W   = SQ_W + 2;
   localparam int UN_W  = N_W - 1;

   // (-b +/- s) / 2a in Q16.16: numerator scaled by 2^15
   localparam int ROOT_SHIFT = 15;
   localparam int NUM_W      = UN_W + ROOT_SHIFT;
   localparam int Q_W        = 32;
   localparam int REM_W      = COEF_W + Q_W + 1;
   localparam int DIFF_W     = REF_W + 1;
   localparam int SUM_W      = DIFF_W + 2;

   localparam logic [0:0] BRANCH_PLUS  = 1'b0;
   localparam logic [0:0] BRANCH_MINUS = 1'b1;
   localparam logic [0:0] STATUS_OK        = 1'b0;
   localparam logic [0:0] STATUS_LEAD_ZERO = 1'b1;

   typedef struct packed {
      logic                         lead_neg;
      logic                         lead_zero;
      logic [COEF_W-1:0]            lin;
      logic [COEF_W-1:0]            lead_mag;
      logic [NREF-1:0][REF_W-1:0]   refs;
   } ctx_type;

endpackage

FILE: hdl/quadratic_lane_point_predictor.sv
// quadratic lane point predictor
// input channel req_*: one lane fit a*x^2 + b*x + c0 (Q24.24), a start row and
// four reference x positions (Q16.16) per beat. result channel rsp_*: the chosen
// root at the target row, the chosen branch and a status code.
// a beat whose start row lies below the target row yields no result; a zero
// leading coefficient yields one result with status 1.
// the square root pipeline has 50 one-bit steps and the divider pipelines have
// 32 one-bit steps, besides the product, discriminant and sum stages.
// throughput: one beat per cycle; every stage is a register with a valid bit.
// when the receiver holds rsp_ready low with a result waiting, the whole
// pipeline freezes and req_ready falls in the same cycle; nothing is dropped.
// a new beat is taken while the waiting result is being taken.
// reset (synchronous, active high) clears all valid bits; the block is ready
// in the first cycle after reset.
module quadratic_lane_point_predictor (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [qlpp_pkg::COEF_W-1:0]    req_lead_coef,
   input  logic signed [qlpp_pkg::COEF_W-1:0]    req_linear_coef,
   input  logic signed [qlpp_pkg::COEF_W-1:0]    req_const_coef,
   input  logic        [qlpp_pkg::ROW_W-1:0]     req_start_row,
   input  logic signed [qlpp_pkg::REF_W-1:0]     req_ref_x_first,
   input  logic signed [qlpp_pkg::REF_W-1:0]     req_ref_x_quarter,
   input  logic signed [qlpp_pkg::REF_W-1:0]     req_ref_x_half,
   input  logic signed [qlpp_pkg::REF_W-1:0]     req_ref_x_three_quarter,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [qlpp_pkg::REF_W-1:0]     rsp_predicted_x,
   output logic                                  rsp_chosen_branch,
   output logic                                  rsp_status_code
);

   localparam int COEF_W = qlpp_pkg::COEF_W;
   localparam int ROW_W  = qlpp_pkg::ROW_W;
   localparam int REF_W  = qlpp_pkg::REF_W;
   localparam int NREF   = qlpp_pkg::NREF;
   localparam int NROW   = qlpp_pkg::NROW;
   localparam int NDIV   = qlpp_pkg::NDIV;
   localparam int HALF_W = qlpp_pkg::HALF_W;
   localparam int PROD_W = qlpp_pkg::PROD_W;
   localparam int RAD_W  = qlpp_pkg::RAD_W;
   localparam int SQ_W   = qlpp_pkg::SQ_W;
   localparam int N_W    = qlpp_pkg::N_W;
   localparam int UN_W   = qlpp_pkg::UN_W;
   localparam int NUM_W  = qlpp_pkg::NUM_W;
   localparam int Q_W    = qlpp_pkg::Q_W;
   localparam int REM_W  = qlpp_pkg::REM_W;
   localparam int DIFF_W = qlpp_pkg::DIFF_W;
   localparam int SUM_W  = qlpp_pkg::SUM_W;
   localparam int FRAC   = qlpp_pkg::COEF_FRAC_BITS;

   logic adv;

   // stage 0: rows and c magnitudes
   logic                 s0_v_ff, s0_v_in;
   qlpp_pkg::ctx_type    s0_ctx_ff, s0_ctx_in;
   logic [COEF_W-1:0]    s0_cmag_ff [NROW], s0_cmag_in [NROW];
   logic                 s0_opp_ff [NROW], s0_opp_in [NROW];

   // stage 1: 24x24 partial products
   logic                 pp_v_ff;
   qlpp_pkg::ctx_type    pp_ctx_ff;
   logic [2*HALF_W-1:0]  pp_bb_ff [4], pp_bb_in [4];
   logic [2*HALF_W-1:0]  pp_ac_ff [NROW][4], pp_ac_in [NROW][4];
   logic                 pp_opp_ff [NROW];

   // stage 2: full products
   logic                 pr_v_ff;
   qlpp_pkg::ctx_type    pr_ctx_ff;
   logic [PROD_W-1:0]    pr_bb_ff, pr_bb_in;
   logic [PROD_W-1:0]    pr_ac_ff [NROW], pr_ac_in [NROW];
   logic                 pr_opp_ff [NROW];

   // square root pipeline, index 0 holds the discriminant
   logic                 sq_v_ff [SQ_W+1], sq_v_in [SQ_W+1];
   qlpp_pkg::ctx_type    sq_ctx_ff [SQ_W+1], sq_ctx_in [SQ_W+1];
   logic [RAD_W-1:0]     sq_op_ff [SQ_W+1][NROW], sq_op_in [SQ_W+1][NROW];
   logic [RAD_W-1:0]     sq_res_ff [SQ_W+1][NROW], sq_res_in [SQ_W+1][NROW];

   // divider pipelines, index 0 holds the numerators; lane 2*row + branch
   logic                 dv_v_ff [Q_W+1], dv_v_in [Q_W+1];
   qlpp_pkg::ctx_type    dv_ctx_ff [Q_W+1], dv_ctx_in [Q_W+1];
   logic [REM_W-1:0]     dv_rem_ff [Q_W+1][NDIV], dv_rem_in [Q_W+1][NDIV];
   logic [Q_W-1:0]       dv_q_ff [Q_W+1][NDIV], dv_q_in [Q_W+1][NDIV];
   logic                 dv_neg_ff [Q_W+1][NDIV], dv_neg_in [Q_W+1][NDIV];
   logic                 dv_ovf_ff [Q_W+1][NDIV], dv_ovf_in [Q_W+1][NDIV];

   // saturated roots
   logic                 rt_v_ff;
   qlpp_pkg::ctx_type    rt_ctx_ff;
   logic [REF_W-1:0]     rt_ff [NDIV], rt_in [NDIV];

   // absolute differences
   logic                 df_v_ff, df_zero_ff;
   logic [DIFF_W-1:0]    df_ff [2*NREF], df_in [2*NREF];
   logic [REF_W-1:0]     df_tgt_ff [2];

   // branch sums
   logic                 sm_v_ff, sm_zero_ff;
   logic [SUM_W-1:0]     sm_p_ff, sm_m_ff, sm_p_in, sm_m_in;
   logic [REF_W-1:0]     sm_tgt_ff [2];

   // result register
   logic                 rsp_valid_ff;
   logic [REF_W-1:0]     rsp_x_ff, rsp_x_in;
   logic                 rsp_branch_ff, rsp_branch_in;
   logic                 rsp_status_ff, rsp_status_in;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // ---------------- stage 0 ----------------
   always_comb begin
      logic [ROW_W:0]      k;
      logic [ROW_W+2:0]    k3;
      logic [ROW_W-1:0]    rows [NROW];
      logic [COEF_W:0]     c_full;
      logic [COEF_W:0]     c_neg;
      k  = (ROW_W+1)'(qlpp_pkg::IMAGE_ROWS - 1) - {1'b0, req_start_row};
      k3 = {1'b0, k, 1'b0} + {2'b00, k};
      rows[0] = req_start_row + ROW_W'(3);
      rows[1] = req_start_row + {1'b0, k[ROW_W:2]};
      rows[2] = req_start_row + {1'b0, k[ROW_W-1:1]};
      rows[3] = req_start_row + k3[ROW_W+1:2];
      rows[4] = ROW_W'(qlpp_pkg::TARGET_ROW);
      // no result when the fit starts below the target row
      s0_v_in = req_valid && (req_start_row <= ROW_W'(qlpp_pkg::TARGET_ROW));
      s0_ctx_in.lead_neg  = req_lead_coef[COEF_W-1];
      s0_ctx_in.lead_zero = (req_lead_coef == '0);
      s0_ctx_in.lin       = req_linear_coef;
      s0_ctx_in.lead_mag  = req_lead_coef[COEF_W-1] ? COEF_W'(-req_lead_coef)
                                                    : req_lead_coef;
      s0_ctx_in.refs[0] = req_ref_x_first;
      s0_ctx_in.refs[1] = req_ref_x_quarter;
      s0_ctx_in.refs[2] = req_ref_x_half;
      s0_ctx_in.refs[3] = req_ref_x_three_quarter;
      for (int r = 0; r < NROW; r++) begin
         c_full = {req_const_coef[COEF_W-1], req_const_coef}
                  - ((COEF_W+1)'(rows[r]) << FRAC);
         c_neg  = ~c_full + (COEF_W+1)'(1);
         s0_cmag_in[r] = c_full[COEF_W] ? c_neg[COEF_W-1:0] : c_full[COEF_W-1:0];
         // a*c < 0 makes the discriminant a sum
         s0_opp_in[r]  = (c_full != '0) && (c_full[COEF_W] != req_lead_coef[COEF_W-1]);
      end
   end

   // ---------------- stage 1 ----------------
   always_comb begin
      logic [COEF_W-1:0] ub;
      logic [COEF_W-1:0] ua;
      ub = s0_ctx_ff.lin[COEF_W-1] ? COEF_W'(-s0_ctx_ff.lin) : s0_ctx_ff.lin;
      ua = s0_ctx_ff.lead_mag;
      pp_bb_in[0] = (2*HALF_W)'(ub[HALF_W-1:0])      * (2*HALF_W)'(ub[HALF_W-1:0]);
      pp_bb_in[1] = (2*HALF_W)'(ub[HALF_W-1:0])      * (2*HALF_W)'(ub[COEF_W-1:HALF_W]);
      pp_bb_in[2] = (2*HALF_W)'(ub[COEF_W-1:HALF_W]) * (2*HALF_W)'(ub[HALF_W-1:0]);
      pp_bb_in[3] = (2*HALF_W)'(ub[COEF_W-1:HALF_W]) * (2*HALF_W)'(ub[COEF_W-1:HALF_W]);
      for (int r = 0; r < NROW; r++) begin
         pp_ac_in[r][0] = (2*HALF_W)'(ua[HALF_W-1:0])
                        * (2*HALF_W)'(s0_cmag_ff[r][HALF_W-1:0]);
         pp_ac_in[r][1] = (2*HALF_W)'(ua[HALF_W-1:0])
                        * (2*HALF_W)'(s0_cmag_ff[r][COEF_W-1:HALF_W]);
         pp_ac_in[r][2] = (2*HALF_W)'(ua[COEF_W-1:HALF_W])
                        * (2*HALF_W)'(s0_cmag_ff[r][HALF_W-1:0]);
         pp_ac_in[r][3] = (2*HALF_W)'(ua[COEF_W-1:HALF_W])
                        * (2*HALF_W)'(s0_cmag_ff[r][COEF_W-1:HALF_W]);
      end
   end

   // ---------------- stage 2 ----------------
   always_comb begin
      pr_bb_in = PROD_W'(pp_bb_ff[0])
               + ((PROD_W'(pp_bb_ff[1]) + PROD_W'(pp_bb_ff[2])) << HALF_W)
               + (PROD_W'(pp_bb_ff[3]) << COEF_W);
      for (int r = 0; r < NROW; r++) begin
         pr_ac_in[r] = PROD_W'(pp_ac_ff[r][0])
                     + ((PROD_W'(pp_ac_ff[r][1]) + PROD_W'(pp_ac_ff[r][2])) << HALF_W)
                     + (PROD_W'(pp_ac_ff[r][3]) << COEF_W);
      end
   end

   // ---------------- discriminant and square root steps ----------------
   always_comb begin
      logic [RAD_W-1:0] bb;
      logic [RAD_W-1:0] ac4;
      logic [RAD_W-1:0] one;
      logic [RAD_W-1:0] trial;
      bb = RAD_W'(pr_bb_ff);
      sq_v_in[0]   = pr_v_ff;
      sq_ctx_in[0] = pr_ctx_ff;
      for (int r = 0; r < NROW; r++) begin
         ac4 = RAD_W'(pr_ac_ff[r]) << 2;
         if (pr_opp_ff[r]) begin
            sq_op_in[0][r] = bb + ac4;
         end else if (bb > ac4) begin
            sq_op_in[0][r] = bb - ac4;
         end else begin
            sq_op_in[0][r] = '0;
         end
         sq_res_in[0][r] = '0;
      end
      for (int i = 0; i < SQ_W; i++) begin
         sq_v_in[i+1]   = sq_v_ff[i];
         sq_ctx_in[i+1] = sq_ctx_ff[i];
         one = RAD_W'(1) << (2 * (SQ_W - 1 - i));
         for (int r = 0; r < NROW; r++) begin
            trial = sq_res_ff[i][r] + one;
            if (sq_op_ff[i][r] >= trial) begin
               sq_op_in[i+1][r]  = sq_op_ff[i][r] - trial;
               sq_res_in[i+1][r] = (sq_res_ff[i][r] >> 1) + one;
            end else begin
               sq_op_in[i+1][r]  = sq_op_ff[i][r];
               sq_res_in[i+1][r] = sq_res_ff[i][r] >> 1;
            end
         end
      end
   end

   // ---------------- numerators and divider steps ----------------
   always_comb begin
      logic [N_W-1:0]   nb;
      logic [N_W-1:0]   s;
      logic [N_W-1:0]   n;
      logic [UN_W-1:0]  un;
      logic [REM_W-1:0] num;
      logic [REM_W-1:0] dsr;
      nb = -{{(N_W-COEF_W){sq_ctx_ff[SQ_W].lin[COEF_W-1]}}, sq_ctx_ff[SQ_W].lin};
      dv_v_in[0]   = sq_v_ff[SQ_W];
      dv_ctx_in[0] = sq_ctx_ff[SQ_W];
      for (int d = 0; d < NDIV; d++) begin
         s   = N_W'(sq_res_ff[SQ_W][d/2][SQ_W-1:0]);
         n   = (d % 2 == 0) ? nb + s : nb - s;
         un  = n[N_W-1] ? UN_W'(-n) : n[UN_W-1:0];
         num = REM_W'({un, {qlpp_pkg::ROOT_SHIFT{1'b0}}});
         dv_rem_in[0][d] = num;
         dv_q_in[0][d]   = '0;
         dv_neg_in[0][d] = n[N_W-1] != sq_ctx_ff[SQ_W].lead_neg;
         // quotient of 2^32 or more saturates either way
         dv_ovf_in[0][d] = num >= (REM_W'(sq_ctx_ff[SQ_W].lead_mag) << Q_W);
      end
      for (int j = 0; j < Q_W; j++) begin
         dv_v_in[j+1]   = dv_v_ff[j];
         dv_ctx_in[j+1] = dv_ctx_ff[j];
         dsr = REM_W'(dv_ctx_ff[j].lead_mag) << (Q_W - 1 - j);
         for (int d = 0; d < NDIV; d++) begin
            dv_neg_in[j+1][d] = dv_neg_ff[j][d];
            dv_ovf_in[j+1][d] = dv_ovf_ff[j][d];
            if (dv_rem_ff[j][d] >= dsr) begin
               dv_rem_in[j+1][d] = dv_rem_ff[j][d] - dsr;
               dv_q_in[j+1][d]   = dv_q_ff[j][d] | (Q_W'(1) << (Q_W - 1 - j));
            end else begin
               dv_rem_in[j+1][d] = dv_rem_ff[j][d];
               dv_q_in[j+1][d]   = dv_q_ff[j][d];
            end
         end
      end
   end

   // ---------------- saturation ----------------
   always_comb begin
      logic [Q_W-1:0] q;
      for (int d = 0; d < NDIV; d++) begin
         q = dv_q_ff[Q_W][d];
         if (dv_neg_ff[Q_W][d]) begin
            if (dv_ovf_ff[Q_W][d] || (q > {1'b1, {(Q_W-1){1'b0}}})) begin
               rt_in[d] = {1'b1, {(REF_W-1){1'b0}}};
            end else begin
               rt_in[d] = REF_W'(-q);
            end
         end else begin
            if (dv_ovf_ff[Q_W][d] || q[Q_W-1]) begin
               rt_in[d] = {1'b0, {(REF_W-1){1'b1}}};
            end else begin
               rt_in[d] = REF_W'(q);
            end
         end
      end
   end

   // ---------------- differences and sums ----------------
   always_comb begin
      logic [DIFF_W-1:0] diff;
      for (int e = 0; e < 2*NREF; e++) begin
         diff = {rt_ctx_ff.refs[e/2][REF_W-1], rt_ctx_ff.refs[e/2]}
              - {rt_ff[e][REF_W-1], rt_ff[e]};
         df_in[e] = diff[DIFF_W-1] ? DIFF_W'(-diff) : diff;
      end
      sm_p_in = '0;
      sm_m_in = '0;
      for (int i = 0; i < NREF; i++) begin
         sm_p_in = sm_p_in + SUM_W'(df_ff[2*i]);
         sm_m_in = sm_m_in + SUM_W'(df_ff[2*i+1]);
      end
   end

   // ---------------- branch choice ----------------
   always_comb begin
      logic minus;
      minus = sm_p_ff > sm_m_ff;
      if (sm_zero_ff) begin
         rsp_x_in      = '0;
         rsp_branch_in = qlpp_pkg::BRANCH_PLUS;
         rsp_status_in = qlpp_pkg::STATUS_LEAD_ZERO;
      end else begin
         rsp_x_in      = minus ? sm_tgt_ff[1] : sm_tgt_ff[0];
         rsp_branch_in = minus ? qlpp_pkg::BRANCH_MINUS : qlpp_pkg::BRANCH_PLUS;
         rsp_status_in = qlpp_pkg::STATUS_OK;
      end
   end

   // ---------------- valid bits ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff      <= 1'b0;
         pp_v_ff      <= 1'b0;
         pr_v_ff      <= 1'b0;
         rt_v_ff      <= 1'b0;
         df_v_ff      <= 1'b0;
         sm_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i <= SQ_W; i++) sq_v_ff[i] <= 1'b0;
         for (int j = 0; j <= Q_W; j++) dv_v_ff[j] <= 1'b0;
      end else if (adv) begin
         s0_v_ff      <= s0_v_in;
         pp_v_ff      <= s0_v_ff;
         pr_v_ff      <= pp_v_ff;
         rt_v_ff      <= dv_v_ff[Q_W];
         df_v_ff      <= rt_v_ff;
         sm_v_ff      <= df_v_ff;
         rsp_valid_ff <= sm_v_ff;
         for (int i = 0; i <= SQ_W; i++) sq_v_ff[i] <= sq_v_in[i];
         for (int j = 0; j <= Q_W; j++) dv_v_ff[j] <= dv_v_in[j];
      end
   end

   // ---------------- payload ----------------
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ctx_ff <= s0_ctx_in;
         pp_ctx_ff <= s0_ctx_ff;
         pr_ctx_ff <= pp_ctx_ff;
         pr_bb_ff  <= pr_bb_in;
         for (int k = 0; k < 4; k++) pp_bb_ff[k] <= pp_bb_in[k];
         for (int r = 0; r < NROW; r++) begin
            s0_cmag_ff[r] <= s0_cmag_in[r];
            s0_opp_ff[r]  <= s0_opp_in[r];
            pp_opp_ff[r]  <= s0_opp_ff[r];
            pr_opp_ff[r]  <= pp_opp_ff[r];
            pr_ac_ff[r]   <= pr_ac_in[r];
            for (int k = 0; k < 4; k++) pp_ac_ff[r][k] <= pp_ac_in[r][k];
         end
         for (int i = 0; i <= SQ_W; i++) begin
            sq_ctx_ff[i] <= sq_ctx_in[i];
            for (int r = 0; r < NROW; r++) begin
               sq_op_ff[i][r]  <= sq_op_in[i][r];
               sq_res_ff[i][r] <= sq_res_in[i][r];
            end
         end
         for (int j = 0; j <= Q_W; j++) begin
            dv_ctx_ff[j] <= dv_ctx_in[j];
            for (int d = 0; d < NDIV; d++) begin
               dv_rem_ff[j][d] <= dv_rem_in[j][d];
               dv_q_ff[j][d]   <= dv_q_in[j][d];
               dv_neg_ff[j][d] <= dv_neg_in[j][d];
               dv_ovf_ff[j][d] <= dv_ovf_in[j][d];
            end
         end
         rt_ctx_ff <= dv_ctx_ff[Q_W];
         for (int d = 0; d < NDIV; d++) rt_ff[d] <= rt_in[d];
         for (int e = 0; e < 2*NREF; e++) df_ff[e] <= df_in[e];
         df_zero_ff   <= rt_ctx_ff.lead_zero;
         df_tgt_ff[0] <= rt_ff[2*NREF];
         df_tgt_ff[1] <= rt_ff[2*NREF+1];
         sm_p_ff      <= sm_p_in;
         sm_m_ff      <= sm_m_in;
         sm_zero_ff   <= df_zero_ff;
         sm_tgt_ff[0] <= df_tgt_ff[0];
         sm_tgt_ff[1] <= df_tgt_ff[1];
         rsp_x_ff      <= rsp_x_in;
         rsp_branch_ff <= rsp_branch_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_predicted_x   = rsp_x_ff;
   assign rsp_chosen_branch = rsp_branch_ff;
   assign rsp_status_code   = rsp_status_ff;

endmodule

FILE: hdl/qlpp_checker.sv
`include "quadratic_lane_point_predictor_macros.svh"

module qlpp_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [qlpp_pkg::REF_W-1:0]     rsp_predicted_x,
   input logic                                  rsp_chosen_branch,
   input logic                                  rsp_status_code
);

   // a stalled result beat holds
   `QLPP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_predicted_x) && $stable(rsp_chosen_branch)
      && $stable(rsp_status_code))

   // a stall at the output freezes the input side too
   `QLPP_ASSERT_SAME(a_stall_back, clock, reset, rsp_valid && !rsp_ready, !req_ready)

   // the pipeline comes out of reset empty
   `QLPP_ASSERT_SAME(a_reset_empty, clock, reset, $past(reset), !rsp_valid)

   // a zero leading coefficient reports zero on the plus branch
   `QLPP_ASSERT_SAME(a_zero_lead, clock, reset,
      rsp_valid && (rsp_status_code == qlpp_pkg::STATUS_LEAD_ZERO),
      (rsp_predicted_x == '0) && (rsp_chosen_branch == qlpp_pkg::BRANCH_PLUS))

endmodule

bind quadratic_lane_point_predictor qlpp_checker u_qlpp_checker (.*);
